/* design/fba_pkg.sv */
// Shared constants, codes and control types of the first-fit block allocator.
`default_nettype none
package fba_pkg;

   localparam int HEAP_BYTES_DEF = 4096;
   localparam int ALIGN_BYTES    = 8;
   localparam int ADDR_W         = 32;
   localparam int SIZE_W         = 32;
   localparam int HSIZE_W        = 13;
   localparam int COPY_W         = 13;
   localparam int USED_W         = 13;
   localparam int CNT_W          = 10;
   localparam int CSR_IDX_W      = 2;
   localparam int HEAP_SIZE_RST  = 4096;

   typedef enum logic [2:0] {
      OP_INIT     = 3'd0,
      OP_ALLOC    = 3'd1,
      OP_FREE     = 3'd2,
      OP_REALLOC  = 3'd3,
      OP_VALIDATE = 3'd4
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HEAP_BASE = 2'd0,
      CSR_HEAP_SIZE = 2'd1
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DISPATCH,
      ST_WALK,
      ST_SPLIT,
      ST_FREE_RD,
      ST_FREE_WR,
      ST_DONE
   } ctl_state_type;

   typedef struct packed {
      logic capture;
      logic seg_load;
      logic clr_step;
      logic walk_start;
      logic walk_step;
      logic take;
      logic split_wr;
      logic val_done;
      logic free_rd;
      logic free_wr;
      logic load_rsp;
   } dp_cmd_type;

   typedef struct packed {
      logic [2:0] op;
      logic       is_null;
      logic       size_zero;
      logic       early_fail;
      logic       misaligned;
      logic       walk_end;
      logic       hit;
      logic       clr_last;
      logic       rsp_free;
   } dp_status_type;

endpackage
`default_nettype wire

/* design/first_fit_block_allocator_top.sv */
// Top level of the first-fit block allocator: controller plus datapath.
//
//   channel  direction  handshake              payload
//   req_     in         req_valid/req_ready    req_type req_size req_address req_null
//   rsp_     out        rsp_valid/rsp_ready    rsp_address rsp_null rsp_copy_length
//                                              rsp_check_passed
//   csr_     in         csr_valid/csr_ready    csr_index csr_wdata
//
// Allocate, reallocate and validate walk the headers one per cycle on the header
// RAM read port; reallocate adds the free steps. Free skips them on a null pointer.
// Init and reset run a clearing pass, and req_ready rises only after it.
// A finished result waits in the output register; an rsp stall also holds the
// controller in its done state. csr writes are always taken.
`default_nettype none
module first_fit_block_allocator_top #(
   parameter int HEAP_BYTES = fba_pkg::HEAP_BYTES_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [fba_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [31:0]                   csr_wdata,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [2:0]                    req_type,
   input  wire logic [fba_pkg::SIZE_W-1:0]    req_size,
   input  wire logic [fba_pkg::ADDR_W-1:0]    req_address,
   input  wire logic                          req_null,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic      [fba_pkg::ADDR_W-1:0]    rsp_address,
   output logic                               rsp_null,
   output logic      [fba_pkg::COPY_W-1:0]    rsp_copy_length,
   output logic                               rsp_check_passed
);
   import fba_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   fba_controller u_ctl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .cmd      (cmd),
      .status   (status)
   );

   fba_datapath #(.HEAP_BYTES(HEAP_BYTES)) u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_type        (req_type),
      .req_size        (req_size),
      .req_address     (req_address),
      .req_null        (req_null),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_address     (rsp_address),
      .rsp_null        (rsp_null),
      .rsp_copy_length (rsp_copy_length),
      .rsp_check_passed(rsp_check_passed),
      .cmd             (cmd),
      .status          (status)
   );
endmodule
`default_nettype wire

/* design/fba_ram.sv */
// Generic single-clock RAM, one write port and one registered read port.
`default_nettype none
module fba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

/* design/fba_datapath.sv */
// Datapath: registers, header store, counters, walk and result logic.
`default_nettype none
module fba_datapath #(
   parameter int HEAP_BYTES = fba_pkg::HEAP_BYTES_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [fba_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [31:0]                     csr_wdata,
   input  wire logic [2:0]                      req_type,
   input  wire logic [fba_pkg::SIZE_W-1:0]      req_size,
   input  wire logic [fba_pkg::ADDR_W-1:0]      req_address,
   input  wire logic                            req_null,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic      [fba_pkg::ADDR_W-1:0]      rsp_address,
   output logic                                 rsp_null,
   output logic      [fba_pkg::COPY_W-1:0]      rsp_copy_length,
   output logic                                 rsp_check_passed,
   input  wire fba_pkg::dp_cmd_type             cmd,
   output fba_pkg::dp_status_type               status
);
   import fba_pkg::*;

   localparam int WORDS   = HEAP_BYTES / ALIGN_BYTES;
   localparam int AW      = $clog2(WORDS);
   localparam int HW      = AW + 2;
   localparam int SW      = $clog2(HEAP_BYTES + 1);
   localparam int EW      = SW + 1;
   localparam int CW      = (AW + 1 > CNT_W) ? AW + 1 : CNT_W;
   localparam int CLAMP   = (HEAP_BYTES / 8) * 8;
   localparam int RST_SEG = (HEAP_SIZE_RST > HEAP_BYTES) ? CLAMP : HEAP_SIZE_RST;

   logic [31:0]       base_ff, base_in;
   logic [HSIZE_W-1:0] hsize_ff, hsize_in;
   logic [SW-1:0]     seg_ff, seg_in;
   logic [USED_W-1:0] used_ff, used_in;
   logic [CNT_W-1:0]  freeb_ff, freeb_in, usedb_ff, usedb_in, totb_ff, totb_in;
   logic [2:0]        op_ff, op_in;
   logic [31:0]       size_ff, size_in, addr_ff, addr_in;
   logic              null_ff, null_in;
   logic [HW-1:0]     h_ff, h_in;
   logic [CW-1:0]     fcnt_ff, fcnt_in, ucnt_ff, ucnt_in, tcnt_ff, tcnt_in;
   logic [AW-1:0]     clr_ff, clr_in;
   logic              split_ff, split_in;
   logic [HW-1:0]     n_ff, n_in;
   logic [SW-1:0]     nsize_ff, nsize_in;
   logic [31:0]       res_addr_ff, res_addr_in;
   logic              res_null_ff, res_null_in;
   logic [COPY_W-1:0] copy_ff, copy_in;
   logic              check_ff, check_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [31:0]       rsp_addr_ff, rsp_addr_in;
   logic              rsp_null_ff, rsp_null_in;
   logic [COPY_W-1:0] rsp_copy_ff, rsp_copy_in;
   logic              rsp_check_ff, rsp_check_in;

   logic              wr_en;
   logic [AW-1:0]     wr_addr, rd_addr, w_idx;
   logic [SW:0]       wr_data, rd_data;
   logic [SW-1:0]     rd_size, eff, keep;
   logic              rd_free, hit, split, w_in, early_fail, val_ok;
   logic [EW-1:0]     need;
   logic [HW-1:0]     words, next_h, n_calc;
   logic [31:0]       hs32, off, osz, copy_calc, used_sum, seg32;

   fba_ram #(.WIDTH(SW + 1), .DEPTH(WORDS)) u_hdr_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_comb begin
      hs32 = {19'd0, hsize_ff[HSIZE_W-1:3], 3'b000};
      if (hs32 > 32'(HEAP_BYTES)) begin
         eff = SW'(CLAMP);
      end else if (hs32 < 32'd16) begin
         eff = SW'(16);
      end else begin
         eff = hs32[SW-1:0];
      end
   end

   always_comb begin
      seg32      = 32'(seg_ff);
      words      = HW'(seg_ff >> 3);
      rd_size    = rd_data[SW-1:0];
      rd_free    = rd_data[SW];
      need       = (EW'(size_ff[SW-1:0]) + EW'(7)) & ~EW'(7);
      early_fail = (size_ff == 32'd0) || (size_ff > seg32) ||
                   (32'(need) + 32'(used_ff) > seg32);
      hit        = rd_free && (EW'(rd_size) >= need);
      split      = 32'(rd_size) >= 32'(need) + 32'd8;
      next_h     = h_ff + HW'(1) + HW'(rd_size >> 3);
      n_calc     = h_ff + HW'(1) + HW'(need >> 3);
      keep       = split ? need[SW-1:0] : rd_size;
      used_sum   = 32'(used_ff) + (split ? 32'd8 : 32'd0) + 32'(keep);
      off        = addr_ff - base_ff;
      w_in       = (off >= 32'd8) && (off < seg32);
      w_idx      = AW'((off >> 3) - 32'd1);
      osz        = w_in ? 32'(rd_size) : 32'd0;
      copy_calc  = (osz < size_ff) ? osz : size_ff;
      val_ok     = (fcnt_ff == CW'(freeb_ff)) && (ucnt_ff == CW'(usedb_ff)) &&
                   (tcnt_ff == CW'(totb_ff)) && ((freeb_ff + usedb_ff) == totb_ff);
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = clr_ff;
      wr_data = '0;
      rd_addr = h_ff[AW-1:0];
      if (cmd.clr_step) begin
         wr_en   = 1'b1;
         wr_data = (clr_ff == '0) ? {1'b1, seg_ff - SW'(8)} : '0;
      end else if (cmd.take) begin
         wr_en   = 1'b1;
         wr_addr = h_ff[AW-1:0];
         wr_data = {1'b0, keep};
      end else if (cmd.split_wr) begin
         wr_en   = split_ff && (n_ff < words);
         wr_addr = n_ff[AW-1:0];
         wr_data = {1'b1, nsize_ff};
      end else if (cmd.free_wr) begin
         wr_en   = w_in;
         wr_addr = w_idx;
         wr_data = {1'b1, rd_size};
      end
      if (cmd.walk_start) begin
         rd_addr = '0;
      end else if (cmd.walk_step) begin
         rd_addr = next_h[AW-1:0];
      end else if (cmd.free_rd) begin
         rd_addr = w_idx;
      end
   end

   always_comb begin
      base_in      = base_ff;
      hsize_in     = hsize_ff;
      seg_in       = seg_ff;
      used_in      = used_ff;
      freeb_in     = freeb_ff;
      usedb_in     = usedb_ff;
      totb_in      = totb_ff;
      op_in        = op_ff;
      size_in      = size_ff;
      addr_in      = addr_ff;
      null_in      = null_ff;
      h_in         = h_ff;
      fcnt_in      = fcnt_ff;
      ucnt_in      = ucnt_ff;
      tcnt_in      = tcnt_ff;
      clr_in       = clr_ff;
      split_in     = split_ff;
      n_in         = n_ff;
      nsize_in     = nsize_ff;
      res_addr_in  = res_addr_ff;
      res_null_in  = res_null_ff;
      copy_in      = copy_ff;
      check_in     = check_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_addr_in  = rsp_addr_ff;
      rsp_null_in  = rsp_null_ff;
      rsp_copy_in  = rsp_copy_ff;
      rsp_check_in = rsp_check_ff;

      if (csr_valid) begin
         if (csr_index == CSR_HEAP_BASE) begin
            base_in = csr_wdata;
         end else if (csr_index == CSR_HEAP_SIZE) begin
            hsize_in = csr_wdata[HSIZE_W-1:0];
         end
      end
      if (cmd.capture) begin
         op_in       = req_type;
         size_in     = req_size;
         addr_in     = req_address;
         null_in     = req_null;
         res_addr_in = '0;
         res_null_in = 1'b1;
         copy_in     = '0;
         check_in    = 1'b0;
      end
      if (cmd.seg_load) begin
         seg_in   = eff;
         used_in  = USED_W'(8);
         freeb_in = CNT_W'(1);
         usedb_in = '0;
         totb_in  = CNT_W'(1);
         clr_in   = '0;
      end
      if (cmd.clr_step) begin
         clr_in = clr_ff + AW'(1);
      end
      if (cmd.walk_start) begin
         h_in    = '0;
         fcnt_in = '0;
         ucnt_in = '0;
         tcnt_in = '0;
      end
      if (cmd.walk_step) begin
         h_in    = next_h;
         fcnt_in = fcnt_ff + CW'(rd_free);
         ucnt_in = ucnt_ff + CW'(!rd_free);
         tcnt_in = tcnt_ff + CW'(1);
      end
      if (cmd.take) begin
         used_in     = used_sum[USED_W-1:0];
         freeb_in    = freeb_ff + CNT_W'(split) - CNT_W'(1);
         totb_in     = totb_ff + CNT_W'(split);
         usedb_in    = usedb_ff + CNT_W'(1);
         res_addr_in = base_ff + ((32'(h_ff[AW-1:0]) + 32'd1) << 3);
         res_null_in = 1'b0;
         split_in    = split;
         n_in        = n_calc;
         nsize_in    = SW'(32'(rd_size) - 32'(need) - 32'd8);
      end
      if (cmd.val_done) begin
         check_in = val_ok;
      end
      if (cmd.free_wr) begin
         if (w_in) begin
            used_in  = used_ff - USED_W'(rd_size);
            freeb_in = freeb_ff + CNT_W'(1);
            usedb_in = usedb_ff - CNT_W'(1);
         end
         if (op_ff == OP_REALLOC && !res_null_ff) begin
            copy_in = copy_calc[COPY_W-1:0];
         end
      end
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_addr_in  = res_addr_ff;
         rsp_null_in  = res_null_ff;
         rsp_copy_in  = copy_ff;
         rsp_check_in = check_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= '0;
         hsize_ff     <= HSIZE_W'(HEAP_SIZE_RST);
         seg_ff       <= SW'(RST_SEG);
         used_ff      <= USED_W'(8);
         freeb_ff     <= CNT_W'(1);
         usedb_ff     <= '0;
         totb_ff      <= CNT_W'(1);
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         base_ff      <= base_in;
         hsize_ff     <= hsize_in;
         seg_ff       <= seg_in;
         used_ff      <= used_in;
         freeb_ff     <= freeb_in;
         usedb_ff     <= usedb_in;
         totb_ff      <= totb_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      size_ff      <= size_in;
      addr_ff      <= addr_in;
      null_ff      <= null_in;
      h_ff         <= h_in;
      fcnt_ff      <= fcnt_in;
      ucnt_ff      <= ucnt_in;
      tcnt_ff      <= tcnt_in;
      split_ff     <= split_in;
      n_ff         <= n_in;
      nsize_ff     <= nsize_in;
      res_addr_ff  <= res_addr_in;
      res_null_ff  <= res_null_in;
      copy_ff      <= copy_in;
      check_ff     <= check_in;
      rsp_addr_ff  <= rsp_addr_in;
      rsp_null_ff  <= rsp_null_in;
      rsp_copy_ff  <= rsp_copy_in;
      rsp_check_ff <= rsp_check_in;
   end

   assign csr_ready        = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_address      = rsp_addr_ff;
   assign rsp_null         = rsp_null_ff;
   assign rsp_copy_length  = rsp_copy_ff;
   assign rsp_check_passed = rsp_check_ff;

   assign status.op         = op_ff;
   assign status.is_null    = null_ff;
   assign status.size_zero  = (size_ff == 32'd0);
   assign status.early_fail = early_fail;
   assign status.misaligned = (base_ff[2:0] != 3'd0);
   assign status.walk_end   = (h_ff >= words);
   assign status.hit        = hit;
   assign status.clr_last   = (clr_ff == AW'(WORDS - 1));
   assign status.rsp_free   = !rsp_valid_ff || rsp_ready;

   a_walk_advances: assert property (@(posedge clock) disable iff (reset)
      cmd.walk_step |=> h_ff > $past(h_ff))
      else $error("walk pointer did not advance");
   a_take_marks_used: assert property (@(posedge clock) disable iff (reset)
      cmd.take |=> !res_null_ff && (usedb_ff == $past(usedb_ff) + CNT_W'(1)))
      else $error("allocation did not record a used block");
endmodule
`default_nettype wire

/* design/fba_controller.sv */
// Controller state machine: sequences clear, walk, split and free steps.
`default_nettype none
module fba_controller (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   output fba_pkg::dp_cmd_type         cmd,
   input  wire fba_pkg::dp_status_type status
);
   import fba_pkg::*;

   ctl_state_type state_ff, state_in;
   logic          init_ff, init_in;

   always_comb begin
      state_in = state_ff;
      init_in  = init_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (status.clr_last) begin
               state_in = init_ff ? ST_DONE : ST_IDLE;
               init_in  = 1'b0;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            case (status.op)
               OP_INIT: begin
                  state_in = ST_CLEAR;
                  init_in  = 1'b1;
               end
               OP_ALLOC: begin
                  state_in = status.early_fail ? ST_DONE : ST_WALK;
               end
               OP_FREE: begin
                  state_in = status.is_null ? ST_DONE : ST_FREE_RD;
               end
               OP_REALLOC: begin
                  if (!status.is_null && status.size_zero) begin
                     state_in = ST_FREE_RD;
                  end else begin
                     state_in = status.early_fail ? ST_DONE : ST_WALK;
                  end
               end
               OP_VALIDATE: begin
                  state_in = status.misaligned ? ST_DONE : ST_WALK;
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_WALK: begin
            if (status.walk_end) begin
               state_in = ST_DONE;
            end else if (status.op != OP_VALIDATE && status.hit) begin
               state_in = ST_SPLIT;
            end
         end
         ST_SPLIT: begin
            state_in = (status.op == OP_REALLOC && !status.is_null) ? ST_FREE_RD : ST_DONE;
         end
         ST_FREE_RD: begin
            state_in = ST_FREE_WR;
         end
         ST_FREE_WR: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (status.rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
         end
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_DISPATCH: begin
            cmd.seg_load   = (status.op == OP_INIT);
            cmd.walk_start = ((status.op == OP_ALLOC || status.op == OP_REALLOC) &&
                              !status.early_fail &&
                              !(status.op == OP_REALLOC && !status.is_null &&
                                status.size_zero)) ||
                             (status.op == OP_VALIDATE && !status.misaligned);
         end
         ST_WALK: begin
            if (status.walk_end) begin
               cmd.val_done = (status.op == OP_VALIDATE);
            end else if (status.op != OP_VALIDATE && status.hit) begin
               cmd.take = 1'b1;
            end else begin
               cmd.walk_step = 1'b1;
            end
         end
         ST_SPLIT: begin
            cmd.split_wr = 1'b1;
         end
         ST_FREE_RD: begin
            cmd.free_rd = 1'b1;
         end
         ST_FREE_WR: begin
            cmd.free_wr = 1'b1;
         end
         ST_DONE: begin
            cmd.load_rsp = status.rsp_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         init_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         init_ff  <= init_in;
      end
   end

   a_accept_dispatch: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> state_ff == ST_DISPATCH)
      else $error("accepted transaction not dispatched");
   a_one_writer: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.clr_step, cmd.take, cmd.split_wr, cmd.free_wr}))
      else $error("header store written by two steps");
   a_take_then_split: assert property (@(posedge clock) disable iff (reset)
      cmd.take |=> state_ff == ST_SPLIT)
      else $error("split step skipped");
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> status.rsp_free)
      else $error("response overwritten");
endmodule
`default_nettype wire
